// ===== design/ccfm_pkg.sv =====
// Shared types, constants and helpers of the classed contact frequency map.
// Used by every module of the block but ccfm_ram; depends on nothing.
`timescale 1ns / 1ps
package ccfm_pkg;

	localparam int MAX_ATOMS  = 256;
	localparam int IDX_W      = 8;                          // atom index width
	localparam int ACNT_W     = 9;                          // atom count, holds MAX_ATOMS
	localparam int PAIR_COUNT = MAX_ATOMS * (MAX_ATOMS - 1) / 2;
	localparam int PAIR_W     = 15;                         // pair address width
	localparam int COORD_W    = 16;
	localparam int COUNT_BITS = 24;
	localparam int FRAC_W     = 17;
	localparam int CUT_W      = 16;
	localparam int LIM_W      = 2 * CUT_W;
	localparam int N_CLASSES  = 3;
	localparam int DRAIN_CYC  = 4;                          // compare pipeline depth
	localparam int DIV_STEPS  = 16;                         // quotient bits below one
	localparam int STEP_W     = 5;

	localparam logic [CUT_W-1:0]  CUTOFF_RESET = 16'd384;
	localparam logic [FRAC_W-1:0] FRAC_ONE     = 17'h10000;

	// opcodes
	localparam logic OP_ATOM = 1'b0;
	localparam logic OP_READ = 1'b1;

	// class codes
	localparam logic [1:0] CLS_UNFOLDED = 2'd0;
	localparam logic [1:0] CLS_FOLDED   = 2'd1;
	localparam logic [1:0] CLS_OTHER    = 2'd2;
	localparam logic [1:0] CLS_SPARE    = 2'd3;

	typedef struct packed {
		logic                      opcode;
		logic signed [COORD_W-1:0] x_pos;
		logic signed [COORD_W-1:0] y_pos;
		logic signed [COORD_W-1:0] z_pos;
		logic [1:0]                frame_class;
		logic                      last_atom;
		logic [IDX_W-1:0]          pair_first;
		logic [IDX_W-1:0]          pair_second;
	} item_t;

	typedef struct packed {
		logic                  pair_valid;
		logic [COUNT_BITS-1:0] unfolded_hits;
		logic [COUNT_BITS-1:0] folded_hits;
		logic [COUNT_BITS-1:0] other_hits;
		logic [FRAC_W-1:0]     unfolded_fraction;
		logic [FRAC_W-1:0]     folded_fraction;
		logic [FRAC_W-1:0]     other_fraction;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic accept;    // capture the incoming item
		logic clr;       // write zero to the counter memories
		logic base;      // compute pair base and squared cutoff
		logic issue;     // issue one distance test
		logic store;     // write coordinates, update counts
		logic raddr;     // compute readout pair address
		logic rd_sel;    // counter memories read the readout address
		logic rload;     // load counts into the dividers
		logic div_step;  // one quotient bit per lane
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic loop_done;
	} ctrl_status_t;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
		sat_inc = (c == {COUNT_BITS{1'b1}}) ? c : c + 1'b1;
	endfunction

endpackage

// ===== design/ccfm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ccfm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/ccfm_ctrl.sv =====
// Controller of the contact map: clearing pass, atom loop and readout sequence.
// Depends on ccfm_pkg.
`timescale 1ns / 1ps
module ccfm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  opcode,
	input  ccfm_pkg::ctrl_status_t status,
	output ccfm_pkg::ctrl_cmd_t    cmd,
	output logic                  busy,
	output logic                  done
);

	typedef enum logic [10:0] {
		S_CLEAR  = 11'b000_0000_0001,
		S_IDLE   = 11'b000_0000_0010,
		S_BASE   = 11'b000_0000_0100,
		S_LOOP   = 11'b000_0000_1000,
		S_DRAIN  = 11'b000_0001_0000,
		S_STORE  = 11'b000_0010_0000,
		S_RADDR  = 11'b000_0100_0000,
		S_RISSUE = 11'b000_1000_0000,
		S_RLOAD  = 11'b001_0000_0000,
		S_DIV    = 11'b010_0000_0000,
		S_DONE   = 11'b100_0000_0000
	} state_t;

	state_t                        state_q, state_d;
	logic [ccfm_pkg::STEP_W-1:0]   step_q, step_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (status.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = (opcode == ccfm_pkg::OP_READ) ? S_RADDR : S_BASE;
				end
			end
			S_BASE: begin
				cmd.base = 1'b1;
				state_d  = S_LOOP;
			end
			S_LOOP: begin
				cmd.issue = !status.loop_done;
				if (status.loop_done) begin
					state_d = S_DRAIN;
					step_d  = '0;
				end
			end
			S_DRAIN: begin
				step_d = step_q + 1'b1;
				if (step_q == ccfm_pkg::STEP_W'(ccfm_pkg::DRAIN_CYC - 1)) begin
					state_d = S_STORE;
				end
			end
			S_STORE: begin
				cmd.store = 1'b1;
				state_d   = S_IDLE;
			end
			S_RADDR: begin
				cmd.raddr = 1'b1;
				state_d   = S_RISSUE;
			end
			S_RISSUE: begin
				cmd.rd_sel = 1'b1;
				state_d    = S_RLOAD;
			end
			S_RLOAD: begin
				cmd.rd_sel = 1'b1;
				cmd.rload  = 1'b1;
				step_d     = '0;
				state_d    = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				step_d       = step_q + 1'b1;
				if (step_q == ccfm_pkg::STEP_W'(ccfm_pkg::DIV_STEPS - 1)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

// ===== design/ccfm_dp.sv =====
// Datapath of the contact map: coordinate and counter memories, distance
// pipeline, frame counts and the three readout dividers. Depends on ccfm_pkg, ccfm_ram.
`timescale 1ns / 1ps
module ccfm_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ccfm_pkg::ctrl_cmd_t                cmd,
	output ccfm_pkg::ctrl_status_t             status,
	input  ccfm_pkg::item_t                    request,
	output ccfm_pkg::result_t                  result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ccfm_pkg::CUT_W-1:0]         cfg_data
);

	localparam int CW = ccfm_pkg::COUNT_BITS;
	localparam int NC = ccfm_pkg::N_CLASSES;

	ccfm_pkg::item_t                  item_q;
	logic [1:0]                       cls_q;
	logic [ccfm_pkg::CUT_W-1:0]       cutoff_q;
	logic [ccfm_pkg::LIM_W-1:0]       lim_q;
	logic [ccfm_pkg::ACNT_W-1:0]      atom_cnt_q;
	logic [ccfm_pkg::ACNT_W-1:0]      j_q;
	logic [ccfm_pkg::ACNT_W-1:0]      loop_end;
	logic [ccfm_pkg::PAIR_W-1:0]      base_q;
	logic [ccfm_pkg::PAIR_W-1:0]      rd_addr_q;
	logic [ccfm_pkg::PAIR_W-1:0]      clr_addr_q;
	logic                             pv_q;
	logic                             store_ok;
	logic [CW-1:0]                    frames_q [NC];

	// item capture, class folding, cutoff register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= ccfm_pkg::CUTOFF_RESET;
		end else if (cfg_valid) begin
			cutoff_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= request;
			cls_q  <= (request.frame_class == ccfm_pkg::CLS_SPARE) ?
				ccfm_pkg::CLS_OTHER : request.frame_class;
		end
	end

	assign store_ok = (atom_cnt_q < ccfm_pkg::ACNT_W'(ccfm_pkg::MAX_ATOMS));
	assign loop_end = store_ok ? atom_cnt_q : '0;

	// pair base i*(i-1)/2 and squared cutoff
	logic [2*ccfm_pkg::IDX_W-1:0] base_prod;
	always_comb begin
		logic [ccfm_pkg::IDX_W-1:0] i;
		i = atom_cnt_q[ccfm_pkg::IDX_W-1:0];
		base_prod = (2*ccfm_pkg::IDX_W)'(i) *
			(2*ccfm_pkg::IDX_W)'((i == '0) ? i : i - 1'b1);
	end

	always_ff @(posedge clk) begin
		if (cmd.base) begin
			base_q <= base_prod[ccfm_pkg::PAIR_W:1];
			lim_q  <= ccfm_pkg::LIM_W'(cutoff_q) * ccfm_pkg::LIM_W'(cutoff_q);
		end
	end

	// readout pair address
	logic [2*ccfm_pkg::IDX_W-1:0] rd_prod;
	assign rd_prod = (2*ccfm_pkg::IDX_W)'(item_q.pair_first) *
		(2*ccfm_pkg::IDX_W)'(item_q.pair_first - 1'b1);
	always_ff @(posedge clk) begin
		if (cmd.raddr) begin
			rd_addr_q <= rd_prod[ccfm_pkg::PAIR_W:1] + ccfm_pkg::PAIR_W'(item_q.pair_second);
			pv_q      <= (item_q.pair_second < item_q.pair_first);
		end
	end

	// loop index, atom count, clear address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atom_cnt_q <= '0;
			j_q        <= '0;
			clr_addr_q <= '0;
			for (int c = 0; c < NC; c++) begin
				frames_q[c] <= '0;
			end
		end else begin
			if (cmd.clr) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (cmd.base) begin
				j_q <= '0;
			end else if (cmd.issue) begin
				j_q <= j_q + 1'b1;
			end
			if (cmd.store) begin
				if (item_q.last_atom) begin
					atom_cnt_q       <= '0;
					frames_q[cls_q] <= ccfm_pkg::sat_inc(frames_q[cls_q]);
				end else if (store_ok) begin
					atom_cnt_q <= atom_cnt_q + 1'b1;
				end
			end
		end
	end

	assign status.clr_last  = (clr_addr_q == ccfm_pkg::PAIR_W'(ccfm_pkg::PAIR_COUNT - 1));
	assign status.loop_done = (j_q == loop_end);

	// coordinate memory: x, y, z side by side
	logic [3*ccfm_pkg::COORD_W-1:0] coord_rd;
	ccfm_ram #(.WIDTH(3*ccfm_pkg::COORD_W), .DEPTH(ccfm_pkg::MAX_ATOMS)) u_coord (
		.clk   (clk),
		.we    (cmd.store && store_ok),
		.waddr (atom_cnt_q[ccfm_pkg::IDX_W-1:0]),
		.wdata ({item_q.x_pos, item_q.y_pos, item_q.z_pos}),
		.raddr (j_q[ccfm_pkg::IDX_W-1:0]),
		.rdata (coord_rd)
	);

	// counter memories, one per class
	logic [ccfm_pkg::PAIR_W-1:0] issue_addr;
	logic [ccfm_pkg::PAIR_W-1:0] hit_raddr;
	logic [ccfm_pkg::PAIR_W-1:0] hit_waddr;
	logic [CW-1:0]               hit_wdata;
	logic [CW-1:0]               hit_rd [NC];
	logic [NC-1:0]               hit_we;

	logic                        v_s1, v_s2, v_s3, v_s4;
	logic [ccfm_pkg::PAIR_W-1:0] pa_s1, pa_s2, pa_s3, pa_s4;
	logic [CW-1:0]               cnt_s2, cnt_s3, cnt_s4;
	logic [ccfm_pkg::COORD_W-1:0] dx_s2, dy_s2, dz_s2;
	logic [2*ccfm_pkg::COORD_W-1:0] sx_s3, sy_s3, sz_s3;
	logic                        hit_s4;

	assign issue_addr = base_q + ccfm_pkg::PAIR_W'(j_q);
	assign hit_raddr  = cmd.rd_sel ? rd_addr_q : issue_addr;
	assign hit_waddr  = cmd.clr ? clr_addr_q : pa_s4;
	assign hit_wdata  = cmd.clr ? '0 : ccfm_pkg::sat_inc(cnt_s4);

	for (genvar c = 0; c < NC; c++) begin : g_hits
		assign hit_we[c] = cmd.clr || (v_s4 && hit_s4 && (cls_q == 2'(c)));
		ccfm_ram #(.WIDTH(CW), .DEPTH(ccfm_pkg::PAIR_COUNT)) u_hits (
			.clk   (clk),
			.we    (hit_we[c]),
			.waddr (hit_waddr),
			.wdata (hit_wdata),
			.raddr (hit_raddr),
			.rdata (hit_rd[c])
		);
	end

	// distance pipeline: absolute differences, squares, sum and compare
	function automatic logic [ccfm_pkg::COORD_W-1:0] abs_diff(
		input logic signed [ccfm_pkg::COORD_W-1:0] a,
		input logic signed [ccfm_pkg::COORD_W-1:0] b
	);
		logic signed [ccfm_pkg::COORD_W:0] d;
		d = {a[ccfm_pkg::COORD_W-1], a} - {b[ccfm_pkg::COORD_W-1], b};
		abs_diff = d[ccfm_pkg::COORD_W] ? ccfm_pkg::COORD_W'(-d) : d[ccfm_pkg::COORD_W-1:0];
	endfunction

	logic [ccfm_pkg::LIM_W+1:0] dist_sum;
	assign dist_sum = (ccfm_pkg::LIM_W+2)'(sx_s3) + (ccfm_pkg::LIM_W+2)'(sy_s3) +
		(ccfm_pkg::LIM_W+2)'(sz_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		pa_s1  <= issue_addr;
		pa_s2  <= pa_s1;
		cnt_s2 <= hit_rd[cls_q];
		dx_s2  <= abs_diff(item_q.x_pos, coord_rd[3*ccfm_pkg::COORD_W-1:2*ccfm_pkg::COORD_W]);
		dy_s2  <= abs_diff(item_q.y_pos, coord_rd[2*ccfm_pkg::COORD_W-1:ccfm_pkg::COORD_W]);
		dz_s2  <= abs_diff(item_q.z_pos, coord_rd[ccfm_pkg::COORD_W-1:0]);
		pa_s3  <= pa_s2;
		cnt_s3 <= cnt_s2;
		sx_s3  <= dx_s2 * dx_s2;
		sy_s3  <= dy_s2 * dy_s2;
		sz_s3  <= dz_s2 * dz_s2;
		pa_s4  <= pa_s3;
		cnt_s4 <= cnt_s3;
		hit_s4 <= (dist_sum < (ccfm_pkg::LIM_W+2)'(lim_q));
	end

	// readout dividers: restoring, one quotient bit a cycle per class
	logic [CW-1:0]              hits_q [NC];
	logic [CW:0]                rem_q  [NC];
	logic [ccfm_pkg::FRAC_W-1:0] quo_q [NC];
	logic [NC-1:0]              fixed_q;

	always_ff @(posedge clk) begin
		for (int c = 0; c < NC; c++) begin
			if (cmd.rload) begin
				hits_q[c] <= hit_rd[c];
				rem_q[c]  <= (CW+1)'(hit_rd[c]);
				if (frames_q[c] == '0) begin
					quo_q[c]   <= '0;
					fixed_q[c] <= 1'b1;
				end else if (hit_rd[c] >= frames_q[c]) begin
					quo_q[c]   <= ccfm_pkg::FRAC_ONE;
					fixed_q[c] <= 1'b1;
				end else begin
					quo_q[c]   <= '0;
					fixed_q[c] <= 1'b0;
				end
			end else if (cmd.div_step && !fixed_q[c]) begin
				if ({rem_q[c][CW-1:0], 1'b0} >= (CW+1)'(frames_q[c])) begin
					rem_q[c] <= {rem_q[c][CW-1:0], 1'b0} - (CW+1)'(frames_q[c]);
					quo_q[c] <= {quo_q[c][ccfm_pkg::FRAC_W-2:0], 1'b1};
				end else begin
					rem_q[c] <= {rem_q[c][CW-1:0], 1'b0};
					quo_q[c] <= {quo_q[c][ccfm_pkg::FRAC_W-2:0], 1'b0};
				end
			end
		end
	end

	// result fields, all zero for a pair that is not valid
	always_comb begin
		result = '0;
		if (pv_q) begin
			result.pair_valid        = 1'b1;
			result.unfolded_hits     = hits_q[ccfm_pkg::CLS_UNFOLDED];
			result.folded_hits       = hits_q[ccfm_pkg::CLS_FOLDED];
			result.other_hits        = hits_q[ccfm_pkg::CLS_OTHER];
			result.unfolded_fraction = quo_q[ccfm_pkg::CLS_UNFOLDED];
			result.folded_fraction   = quo_q[ccfm_pkg::CLS_FOLDED];
			result.other_fraction    = quo_q[ccfm_pkg::CLS_OTHER];
		end
	end

endmodule

// ===== design/classed_contact_frequency_map.sv =====
// Top level of the classed contact frequency map: controller plus datapath.
// Depends on ccfm_pkg, ccfm_ctrl, ccfm_dp (and ccfm_ram below it).
//
//  channel   handshake                 payload
//  request   start / busy              request  (ccfm_pkg::item_t)
//  result    done (one-cycle strobe)   result   (ccfm_pkg::result_t)
//  config    cfg_valid / cfg_ready     cfg_data (contact cutoff, 16 bit)
//
// An atom item with index i runs i distance tests, one per cycle,
// through a four-stage pipeline fed by the coordinate memory, then drain and store.
// A readout item runs through the 16-step restoring dividers.
// After reset a clearing pass zeroes all 32640 pair entries of the hit counters; busy stays high.
// Results cannot be stalled: each is shown for exactly one cycle with done.
`timescale 1ns / 1ps
module classed_contact_frequency_map (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  ccfm_pkg::item_t             request,
	output logic                        done,
	output ccfm_pkg::result_t           result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ccfm_pkg::CUT_W-1:0]  cfg_data
);

	ccfm_pkg::ctrl_cmd_t    cmd;
	ccfm_pkg::ctrl_status_t status;

	ccfm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (request.opcode),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ccfm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.request   (request),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

`ifndef ASSERT_OFF
	// a result only appears while an item is in work
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe while idle");

	// the strobe lasts a single cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");

	// an atom item never gives a result straight away
	a_atom_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.opcode == ccfm_pkg::OP_ATOM) |=> !done)
		else $error("result after atom item");
`endif

endmodule

// ===== bench/classed_contact_frequency_map_tb.sv =====
// Self-checking testbench for the classed contact frequency map.
// Depends on ccfm_pkg and classed_contact_frequency_map; predicts every readout result.
`timescale 1ns / 1ps
module classed_contact_frequency_map_tb;
	import ccfm_pkg::*;

	localparam longint CNT_SAT = (64'd1 << COUNT_BITS) - 1;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	item_t               request;
	logic                done;
	result_t             result;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CUT_W-1:0]    cfg_data;

	classed_contact_frequency_map u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// predictor state
	logic [CUT_W-1:0]          cutoff_q;
	logic signed [COORD_W-1:0] x_mem [MAX_ATOMS];
	logic signed [COORD_W-1:0] y_mem [MAX_ATOMS];
	logic signed [COORD_W-1:0] z_mem [MAX_ATOMS];
	int                        next_atom;
	longint                    pair_tally [longint];   // key: class * PAIR_COUNT + pair
	longint                    frame_tally [N_CLASSES];
	result_t                   pending_reads [$];

	int  errors;
	int  items_sent;
	int  reads_checked;
	int  idle_pct;

	always #5 clk = ~clk;

	// global timeout
	initial begin
		#50_000_000;
		$display("status: fail");
		$finish;
	end

	task automatic report(input string what, input longint want, input longint got);
		$display("[%0t] mismatch %s: expected %0d got %0d", $realtime, what, want, got);
		errors++;
	endtask

	function automatic longint tally_of(input int cls, input int p);
		longint k;
		k = longint'(cls) * PAIR_COUNT + p;
		return pair_tally.exists(k) ? pair_tally[k] : 0;
	endfunction

	function automatic logic [FRAC_W-1:0] share_of(input longint h, input longint f);
		longint q;
		if (f == 0)
			return '0;
		q = (h << 16) / f;
		return (q > 65536) ? FRAC_ONE : FRAC_W'(q);
	endfunction

	// predictor: apply one accepted item
	task automatic predict_item(input item_t it);
		int                cls;
		int                i;
		int                j;
		int                p;
		longint            dx;
		longint            dy;
		longint            dz;
		longint            lim;
		longint            k;
		result_t           r;
		cls = (it.frame_class == CLS_SPARE) ? int'(CLS_OTHER) : int'(it.frame_class);
		if (it.opcode == OP_ATOM) begin
			if (next_atom < MAX_ATOMS) begin
				i = next_atom;
				lim = longint'(cutoff_q) * longint'(cutoff_q);
				for (j = 0; j < i; j++) begin
					dx = longint'(it.x_pos) - longint'(x_mem[j]);
					dy = longint'(it.y_pos) - longint'(y_mem[j]);
					dz = longint'(it.z_pos) - longint'(z_mem[j]);
					if (dx * dx + dy * dy + dz * dz < lim) begin
						k = longint'(cls) * PAIR_COUNT + i * (i - 1) / 2 + j;
						if (tally_of(cls, i * (i - 1) / 2 + j) < CNT_SAT)
							pair_tally[k] = tally_of(cls, i * (i - 1) / 2 + j) + 1;
					end
				end
				x_mem[i] = it.x_pos;
				y_mem[i] = it.y_pos;
				z_mem[i] = it.z_pos;
				next_atom = i + 1;
			end
			if (it.last_atom) begin
				if (frame_tally[cls] < CNT_SAT)
					frame_tally[cls]++;
				next_atom = 0;
			end
		end else begin
			r = '0;
			i = it.pair_first;
			j = it.pair_second;
			if (j < i) begin
				p = i * (i - 1) / 2 + j;
				r.pair_valid        = 1'b1;
				r.unfolded_hits     = COUNT_BITS'(tally_of(0, p));
				r.folded_hits       = COUNT_BITS'(tally_of(1, p));
				r.other_hits        = COUNT_BITS'(tally_of(2, p));
				r.unfolded_fraction = share_of(tally_of(0, p), frame_tally[0]);
				r.folded_fraction   = share_of(tally_of(1, p), frame_tally[1]);
				r.other_fraction    = share_of(tally_of(2, p), frame_tally[2]);
			end
			pending_reads.push_back(r);
		end
	endtask

	// result checker: each done strobe against the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_reads.size() == 0) begin
				report("result with none expected", 0, 1);
			end else begin
				want = pending_reads.pop_front();
				reads_checked++;
				if (result.pair_valid !== want.pair_valid)
					report("pair_valid", want.pair_valid, result.pair_valid);
				if (result.unfolded_hits !== want.unfolded_hits)
					report("unfolded_hits", want.unfolded_hits, result.unfolded_hits);
				if (result.folded_hits !== want.folded_hits)
					report("folded_hits", want.folded_hits, result.folded_hits);
				if (result.other_hits !== want.other_hits)
					report("other_hits", want.other_hits, result.other_hits);
				if (result.unfolded_fraction !== want.unfolded_fraction)
					report("unfolded_fraction", want.unfolded_fraction,
						result.unfolded_fraction);
				if (result.folded_fraction !== want.folded_fraction)
					report("folded_fraction", want.folded_fraction, result.folded_fraction);
				if (result.other_fraction !== want.other_fraction)
					report("other_fraction", want.other_fraction, result.other_fraction);
			end
		end
	end

	// send one item; start is left high so back-to-back items need no re-raise
	task automatic send_item(input item_t it);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		request <= it;
		start   <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		predict_item(it);
		items_sent++;
	endtask

	task automatic send_atom(input int x, input int y, input int z, input logic [1:0] cls,
			input logic last);
		item_t it;
		it = '0;
		it.opcode      = OP_ATOM;
		it.x_pos       = COORD_W'(x);
		it.y_pos       = COORD_W'(y);
		it.z_pos       = COORD_W'(z);
		it.frame_class = cls;
		it.last_atom   = last;
		it.pair_first  = IDX_W'($urandom);
		it.pair_second = IDX_W'($urandom);
		send_item(it);
	endtask

	task automatic send_read(input int i, input int j);
		item_t it;
		it = '0;
		it.opcode      = OP_READ;
		it.x_pos       = COORD_W'($urandom);
		it.y_pos       = COORD_W'($urandom);
		it.z_pos       = COORD_W'($urandom);
		it.frame_class = 2'($urandom);
		it.last_atom   = 1'($urandom);
		it.pair_first  = IDX_W'(i);
		it.pair_second = IDX_W'(j);
		send_item(it);
	endtask

	// drop start, wait for every result and for the block to settle
	task automatic wait_idle();
		start <= 1'b0;
		do
			@(posedge clk);
		while (busy || pending_reads.size() != 0);
		repeat (DRAIN_CYC + 8) @(posedge clk);
	endtask

	task automatic write_cutoff(input logic [CUT_W-1:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		cutoff_q = v;
	endtask

	// contacts at the default cutoff, invalid pairs, class code three, mid-frame read
	task automatic test_basic_contacts();
		send_atom(0, 0, 0, CLS_UNFOLDED, 1'b0);
		send_atom(383, 0, 0, CLS_UNFOLDED, 1'b0);    // just inside
		send_read(1, 0);                             // mid-frame readout
		send_atom(-384, 0, 0, CLS_UNFOLDED, 1'b0);   // exactly at cutoff from atom 0
		send_atom(32767, -32768, 32767, CLS_UNFOLDED, 1'b1);
		send_read(1, 0);
		send_read(2, 0);
		send_read(3, 2);
		send_read(2, 2);                             // equal indices
		send_read(0, 1);                             // order reversed
		send_read(255, 254);
		send_atom(5, 5, 5, CLS_SPARE, 1'b0);
		send_atom(6, 6, 6, CLS_SPARE, 1'b1);
		send_read(1, 0);
	endtask

	// class switching inside a frame and a fraction above one
	task automatic test_class_switch();
		int f;
		send_atom(10, 10, 10, CLS_FOLDED, 1'b0);
		send_atom(11, 10, 10, CLS_FOLDED, 1'b1);
		for (f = 0; f < 2; f++) begin
			send_atom(10, 10, 10, CLS_FOLDED, 1'b0);
			send_atom(11, 10, 10, CLS_FOLDED, 1'b0);
			send_atom(-32768, 32767, -32768, CLS_OTHER, 1'b1);
		end
		send_read(1, 0);
		send_read(2, 1);
	endtask

	// frame longer than the store
	task automatic test_long_frame();
		int n;
		for (n = 0; n < MAX_ATOMS + 3; n++)
			send_atom($urandom_range(0, 700), $urandom_range(0, 700), $urandom_range(0, 700),
				CLS_FOLDED, n == MAX_ATOMS + 2);
		send_read(255, 254);
		send_read(255, 0);
		send_read(128, 77);
	endtask

	// cutoff extremes
	task automatic test_cutoff_extremes();
		write_cutoff('0);
		send_atom(0, 0, 0, CLS_UNFOLDED, 1'b0);
		send_atom(0, 0, 0, CLS_UNFOLDED, 1'b1);
		send_read(1, 0);
		write_cutoff('1);
		send_atom(-32768, 0, 0, CLS_OTHER, 1'b0);
		send_atom(32767, 0, 0, CLS_OTHER, 1'b0);      // distance equal to cutoff
		send_atom(32766, 0, 0, CLS_OTHER, 1'b0);
		send_atom(32767, 32767, 32767, CLS_OTHER, 1'b1);
		send_read(1, 0);
		send_read(2, 0);
		send_read(3, 0);
		send_read(3, 2);
	endtask

	// random frames with clustered atoms, readouts and noise
	task automatic test_random_traffic(input int n_items, input int pct);
		int stop_at;
		int n;
		int len;
		int bx;
		int by;
		int bz;
		int spread;
		int pick;
		int i;
		logic [1:0] cls;
		idle_pct = pct;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 65) begin
				len = ($urandom_range(19) == 0) ? $urandom_range(12, 40) : $urandom_range(2, 10);
				bx = $urandom;
				by = $urandom;
				bz = $urandom;
				spread = $urandom_range(50, 800);
				cls = 2'($urandom);
				for (n = 0; n < len; n++) begin
					if ($urandom_range(9) == 0)
						cls = 2'($urandom);
					send_atom(bx + $urandom_range(0, spread), by + $urandom_range(0, spread),
						bz + $urandom_range(0, spread), cls, n == len - 1);
				end
			end else if (pick < 92) begin
				i = $urandom_range(1, 12);
				send_read(i, $urandom_range(0, i - 1));
			end else if (pick < 96) begin
				send_read($urandom, $urandom);
			end else begin
				send_atom($urandom, $urandom, $urandom, 2'($urandom), 1'($urandom));
			end
		end
	endtask

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		start     = 1'b0;
		request   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		errors    = 0;
		items_sent = 0;
		reads_checked = 0;
		idle_pct  = 0;
		cutoff_q  = CUTOFF_RESET;
		next_atom = 0;
		foreach (frame_tally[c])
			frame_tally[c] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_basic_contacts();
		test_class_switch();
		test_long_frame();
		test_cutoff_extremes();
		write_cutoff(CUTOFF_RESET);
		test_random_traffic(115, 0);
		wait_idle();                                 // sender holds off until all results are in
		test_random_traffic(115, 69);
		write_cutoff(16'd200);
		test_random_traffic(115, 6);
		write_cutoff(16'd1500);
		test_random_traffic(110, 0);

		wait_idle();
		repeat (40) @(posedge clk);
		$display("covered %0d items, %0d readouts checked, %0d frames per class %0d/%0d/%0d",
			items_sent, reads_checked, frame_tally[0] + frame_tally[1] + frame_tally[2],
			frame_tally[0], frame_tally[1], frame_tally[2]);
		$display("cutoffs 0, 200, 384, 1500, 65535; long frame, class switches, idle gaps");
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
